// File: hdl/itp_pkg.sv
// Shared definitions for the infix-to-postfix converter: token codes,
// operator priorities, default sizes and the emit bundle.
// No dependencies.
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int REF_WIDTH_DEF   = 16;

  typedef logic [3:0] kind_t;

  localparam kind_t K_OPERAND = 4'd0;
  localparam kind_t K_PLUS    = 4'd1;
  localparam kind_t K_MINUS   = 4'd2;
  localparam kind_t K_MUL     = 4'd3;
  localparam kind_t K_DIV     = 4'd4;
  localparam kind_t K_LPAREN  = 4'd5;
  localparam kind_t K_RPAREN  = 4'd6;
  localparam kind_t K_SIN     = 4'd7;
  localparam kind_t K_LN      = 4'd12;
  localparam kind_t K_END     = 4'd13;

  typedef logic [1:0] prio_t;

  localparam prio_t PRIO_PAREN = 2'd0;
  localparam prio_t PRIO_ADD   = 2'd1;
  localparam prio_t PRIO_MUL   = 2'd2;
  localparam prio_t PRIO_FUNC  = 2'd3;

  // One token handed from the sequencer to the output stage.
  typedef struct packed {
    logic  emit;  // new token enters the hold slot
    logic  fin;   // item done: the held token leaves as the last one
    logic  err;
    kind_t kind;
  } emit_t;

endpackage

// File: hdl/itp_stack_ram.sv
// Operator stack storage: one write port, one registered read port.
// Depends on itp_pkg.
module itp_stack_ram import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int IW          = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  kind_t         wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output kind_t         rdata
);

  kind_t mem [STACK_DEPTH];
  kind_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read so a stalled sequencer keeps its operand.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/itp_ctrl.sv
// Sequencer: classifies tokens, pops the operator stack one entry per cycle while
// the output stage is free, pushes operators and tracks the error flag. Depends on itp_pkg.
module itp_ctrl import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int REF_WIDTH   = REF_WIDTH_DEF,
  parameter int IW          = $clog2(STACK_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kind_t                in_cmd,
  input  logic [REF_WIDTH-1:0] in_operand_ref,
  input  logic                 out_free,
  output emit_t                ev,
  output logic [REF_WIDTH-1:0] ev_oref,
  output logic                 mem_we,
  output logic [IW-1:0]        mem_waddr,
  output kind_t                mem_wdata,
  output logic                 mem_re,
  output logic [IW-1:0]        mem_raddr,
  input  kind_t                mem_rdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_ENDMK, S_DRAIN} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          err_r, err_nxt;
  logic          emitted_r, emitted_nxt;
  kind_t         cmd_r, cmd_nxt;

  logic          push_req;
  logic [CW-1:0] push_at;
  kind_t         push_kind;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_dec2;
  state_t        done_state;

  function automatic prio_t prio_of(kind_t k);
    prio_t p;
    p = PRIO_PAREN;
    if (k inside {K_PLUS, K_MINUS}) p = PRIO_ADD;
    else if (k inside {K_MUL, K_DIV}) p = PRIO_MUL;
    else if (k inside {[K_SIN:K_LN]}) p = PRIO_FUNC;
    return p;
  endfunction

  assign in_stall   = (state_r != S_IDLE);
  assign cnt_dec    = cnt_r - CW'(1);
  assign cnt_dec2   = cnt_r - CW'(2);
  assign done_state = emitted_r ? S_DRAIN : S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    emitted_nxt = emitted_r;
    cmd_nxt     = cmd_r;
    ev          = '0;
    ev_oref     = '0;
    mem_re      = 1'b0;
    mem_raddr   = cnt_dec[IW-1:0];
    push_req    = 1'b0;
    push_at     = cnt_r;
    push_kind   = cmd_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          if (in_cmd inside {[K_PLUS:K_DIV]}) begin
            if (cnt_r == '0) begin
              push_req  = 1'b1;
              push_kind = in_cmd;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_EVAL;
            end
          end else if (in_cmd == K_LPAREN || in_cmd inside {[K_SIN:K_LN]}) begin
            push_req  = 1'b1;
            push_kind = in_cmd;
          end else if (in_cmd == K_RPAREN) begin
            if (cnt_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_EVAL;
            end
          end else if (in_cmd == K_END) begin
            if (cnt_r == '0) begin
              state_nxt = S_ENDMK;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_EVAL;
            end
          end else begin
            // Operands, and the two unused codes, pass straight through.
            ev.emit     = 1'b1;
            ev.kind     = K_OPERAND;
            ev.err      = err_r;
            ev_oref     = in_operand_ref;
            emitted_nxt = 1'b1;
            state_nxt   = S_DRAIN;
          end
        end
      end

      S_EVAL: begin
        if (out_free) begin
          mem_raddr = cnt_dec2[IW-1:0];
          cnt_nxt   = cnt_dec;
          case (cmd_r)
            K_RPAREN: begin
              if (mem_rdata == K_LPAREN) begin
                state_nxt = done_state;
              end else begin
                ev.emit     = 1'b1;
                ev.kind     = mem_rdata;
                ev.err      = err_r;
                emitted_nxt = 1'b1;
                if (cnt_dec == '0) begin
                  err_nxt   = 1'b1;
                  state_nxt = S_DRAIN;
                end else begin
                  mem_re = 1'b1;
                end
              end
            end
            K_END: begin
              if (mem_rdata == K_LPAREN) begin
                err_nxt = 1'b1;
              end else begin
                ev.emit     = 1'b1;
                ev.kind     = mem_rdata;
                ev.err      = err_r;
                emitted_nxt = 1'b1;
              end
              if (cnt_dec == '0) state_nxt = S_ENDMK;
              else mem_re = 1'b1;
            end
            default: begin
              if (prio_of(mem_rdata) >= prio_of(cmd_r)) begin
                ev.emit     = 1'b1;
                ev.kind     = mem_rdata;
                ev.err      = err_r;
                emitted_nxt = 1'b1;
                if (cnt_dec == '0) begin
                  push_req  = 1'b1;
                  push_at   = '0;
                  state_nxt = S_DRAIN;
                end else begin
                  mem_re = 1'b1;
                end
              end else begin
                // Lower-priority top stays; push above it.
                push_req  = 1'b1;
                cnt_nxt   = cnt_r;
                state_nxt = done_state;
              end
            end
          endcase
        end
      end

      S_ENDMK: begin
        if (out_free) begin
          ev.emit     = 1'b1;
          ev.kind     = K_END;
          ev.err      = err_r;
          emitted_nxt = 1'b1;
          cnt_nxt     = '0;
          err_nxt     = 1'b0;
          state_nxt   = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (out_free) begin
          ev.fin      = 1'b1;
          emitted_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Drop a push onto a full stack and flag it.
    mem_we    = 1'b0;
    mem_waddr = push_at[IW-1:0];
    mem_wdata = push_kind;
    if (push_req) begin
      if (push_at >= CW'(STACK_DEPTH)) begin
        err_nxt = 1'b1;
      end else begin
        mem_we  = 1'b1;
        cnt_nxt = push_at + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      emitted_r <= 1'b0;
      cmd_r     <= K_OPERAND;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
      emitted_r <= emitted_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

endmodule

// File: hdl/itp_out_stage.sv
// Output stage: a hold slot that delays each token by one emit so the last
// flag is known, followed by the output register. Depends on itp_pkg.
module itp_out_stage import itp_pkg::*; #(
  parameter int REF_WIDTH = REF_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  emit_t                ev,
  input  logic [REF_WIDTH-1:0] ev_oref,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kind_t                out_kind,
  output logic [REF_WIDTH-1:0] out_ref,
  output logic                 out_error,
  output logic                 out_last
);

  logic                 hold_v_r;
  kind_t                hold_kind_r;
  logic                 hold_err_r;
  logic [REF_WIDTH-1:0] hold_ref_r;
  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [REF_WIDTH-1:0] out_ref_r;
  logic                 out_error_r;
  logic                 out_last_r;
  logic                 load;

  assign out_free = !out_valid_r || !out_stall;
  assign load     = hold_v_r && (ev.emit || ev.fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (ev.emit) hold_v_r <= 1'b1;
      else if (ev.fin) hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.emit) begin
      hold_kind_r <= ev.kind;
      hold_err_r  <= ev.err;
      hold_ref_r  <= ev_oref;
    end
    if (load) begin
      out_kind_r  <= hold_kind_r;
      out_ref_r   <= hold_ref_r;
      out_error_r <= hold_err_r;
      out_last_r  <= ev.fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_ref   = out_ref_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

endmodule

// File: hdl/infix_to_postfix_converter_unit.sv
// Top level of the infix-to-postfix converter (shunting-yard).
// Depends on itp_pkg, itp_stack_ram, itp_ctrl and itp_out_stage.
//
// One token is taken per transaction on the in_ channel; postfix tokens leave
// on the out_ channel in order, out_last marking the final one of each input
// transaction. Operator state lives in a single-port-write, registered-read
// stack memory walked by a sequencer that pops one entry per cycle while the
// output stage is free. Steps per input token: an operator that only pushes
// ("(" or a function, or a binary operator onto an empty stack) is just
// accepted; an operand is accepted, then the held token is released; a binary
// operator, ")" or end is accepted, then each stack entry examined is handled
// in turn, then the last token is released when anything was emitted, and end
// also sends the end marker before that release. Back-pressure on out_stall
// holds the sequencer in place. A push onto a full stack, a ")" with no "(", or
// a "(" left at end raise out_error until the end marker, which carries the
// final flag and returns the stack to empty. No clearing pass is needed after
// reset: only entries below the stack count are ever read.
module infix_to_postfix_converter_unit import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int REF_WIDTH   = REF_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_cmd,
  input  logic [REF_WIDTH-1:0] in_operand_ref,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_kind,
  output logic [REF_WIDTH-1:0] out_ref,
  output logic                 out_error,
  output logic                 out_last
);

  localparam int IW = $clog2(STACK_DEPTH);

  emit_t                ev;
  logic [REF_WIDTH-1:0] ev_oref;
  logic                 out_free;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  kind_t                mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  kind_t                mem_rdata;

  // Stack reads and writes never target the same cycle: pushes happen only on
  // cycles that issue no read, so the registered read needs no forwarding.
  itp_stack_ram #(
    .STACK_DEPTH(STACK_DEPTH),
    .IW         (IW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Classify, pop, push and track errors.
  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .REF_WIDTH  (REF_WIDTH),
    .IW         (IW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_operand_ref(in_operand_ref),
    .out_free      (out_free),
    .ev            (ev),
    .ev_oref       (ev_oref),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // Delay each token one emit to attach the last flag, then register it out.
  itp_out_stage #(
    .REF_WIDTH(REF_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev       (ev),
    .ev_oref  (ev_oref),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind (out_kind),
    .out_ref  (out_ref),
    .out_error(out_error),
    .out_last (out_last)
  );

endmodule

// File: hdl/itp_checker.sv
// Port-level checks for the infix-to-postfix converter, bound to the top level.
// Depends on itp_pkg and infix_to_postfix_converter_unit.
module itp_checker import itp_pkg::*; #(
  parameter int REF_WIDTH = REF_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [3:0]           in_cmd,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [3:0]           out_kind,
  input logic [REF_WIDTH-1:0] out_ref,
  input logic                 out_error,
  input logic                 out_last
);

  // The end marker always closes the results of its transaction.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_END |-> out_last)
    else $error("end marker without last flag");

  // Only operands carry a reference.
  a_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_OPERAND |-> out_ref == '0)
    else $error("non-operand token with nonzero reference");

  // An operand or end transaction always produces output, so input must stall.
  a_busy_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == K_OPERAND || in_cmd == K_END) |=> in_stall)
    else $error("input not held while results pending");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_ref)
      && $stable(out_error) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind infix_to_postfix_converter_unit itp_checker #(.REF_WIDTH(REF_WIDTH)) u_itp_checker (.*);

// File: tb/tb_infix_to_postfix_converter_unit.sv
// Self-checking bench for infix_to_postfix_converter_unit: token stream in, postfix out.
// Depends on itp_pkg and the converter RTL; a built-in operator-stack predictor
// supplies the expected postfix tokens.
module tb_infix_to_postfix_converter_unit;
  import itp_pkg::*;

  localparam int ITEM_TARGET = 470;
  localparam int END_DRAIN   = 40;   // cycles to hold after the last expected token
  localparam int LONG_HOLD   = 150;  // receiver hold-off, in cycles

  // Token codes the package does not name.
  localparam kind_t KIND_COS     = 4'd8;
  localparam kind_t KIND_TAN     = 4'd9;
  localparam kind_t KIND_CTG     = 4'd10;
  localparam kind_t KIND_SQRT    = 4'd11;
  localparam kind_t KIND_SPARE14 = 4'd14;
  localparam kind_t KIND_SPARE15 = 4'd15;

  typedef struct {
    kind_t                   cmd;
    logic [REF_WIDTH_DEF-1:0] opref;
    bit                      drain_first;  // hold until every expected token is out
  } infix_token_t;

  typedef struct {
    kind_t                   kind;
    logic [REF_WIDTH_DEF-1:0] opref;
    logic                    err;
    logic                    last;
  } postfix_token_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [3:0]               in_cmd = K_OPERAND;
  logic [REF_WIDTH_DEF-1:0] in_operand_ref = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [3:0]               out_kind;
  logic [REF_WIDTH_DEF-1:0] out_ref;
  logic                     out_error;
  logic                     out_last;

  infix_token_t   infix_tokens[$];     // stimulus not yet offered
  postfix_token_t postfix_expected[$]; // predicted output, oldest first

  // Predictor state: a private copy of the operator stack.
  kind_t op_stack[STACK_DEPTH_DEF];
  int    op_depth = 0;
  bit    err_seen = 1'b0;

  int mismatch_count = 0;
  int accepted_items = 0;
  int tx_gap = 0;
  bit tx_quiet = 1'b0;
  int rx_stall_left = 0;
  bit rx_quiet = 1'b0;
  int hold_cycles = 0;
  int holds_done = 0;
  bit hold_next = 1'b0;

  infix_to_postfix_converter_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_operand_ref (in_operand_ref),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_ref        (out_ref),
    .out_error      (out_error),
    .out_last       (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic prio_t rank_of(kind_t k);
    if (k == K_PLUS || k == K_MINUS) return PRIO_ADD;
    if (k == K_MUL || k == K_DIV) return PRIO_MUL;
    if (k >= K_SIN && k <= K_LN) return PRIO_FUNC;
    return PRIO_PAREN;
  endfunction

  // Queue one postfix token; it carries the error flag as it stands right now.
  task automatic emit_postfix(kind_t k, logic [REF_WIDTH_DEF-1:0] opref);
    postfix_token_t t;
    t.kind  = k;
    t.opref = (k == K_OPERAND) ? opref : '0;
    t.err   = err_seen;
    t.last  = 1'b0;
    postfix_expected.push_back(t);
  endtask

  // A push onto a full stack is dropped and flags the expression.
  task automatic push_operator(kind_t k);
    if (op_depth >= STACK_DEPTH_DEF) begin
      err_seen = 1'b1;
    end else begin
      op_stack[op_depth] = k;
      op_depth++;
    end
  endtask

  task automatic predict_postfix(kind_t cmd, logic [REF_WIDTH_DEF-1:0] opref);
    int emitted;
    bit found;
    emitted = 0;
    found = 1'b0;
    if (cmd >= K_PLUS && cmd <= K_DIV) begin
      // Binary operator: pop everything of equal or higher rank first.
      while (op_depth > 0 && rank_of(op_stack[op_depth - 1]) >= rank_of(cmd)) begin
        op_depth--;
        emit_postfix(op_stack[op_depth], '0);
        emitted++;
      end
      push_operator(cmd);
    end else if (cmd == K_LPAREN || (cmd >= K_SIN && cmd <= K_LN)) begin
      push_operator(cmd);
    end else if (cmd == K_RPAREN) begin
      // Pop down to the matching open; with none, the stack empties and flags.
      while (op_depth > 0 && !found) begin
        op_depth--;
        if (op_stack[op_depth] == K_LPAREN) begin
          found = 1'b1;
        end else begin
          emit_postfix(op_stack[op_depth], '0);
          emitted++;
        end
      end
      if (!found) err_seen = 1'b1;
    end else if (cmd == K_END) begin
      // Flush; a leftover open is swallowed but flags the expression.
      while (op_depth > 0) begin
        op_depth--;
        if (op_stack[op_depth] == K_LPAREN) begin
          err_seen = 1'b1;
        end else begin
          emit_postfix(op_stack[op_depth], '0);
          emitted++;
        end
      end
      emit_postfix(K_END, '0);
      emitted++;
      op_depth = 0;
      err_seen = 1'b0;
    end else begin
      // Operand, and the two spare codes that behave as operands.
      emit_postfix(K_OPERAND, opref);
      emitted++;
    end
    if (emitted > 0) postfix_expected[postfix_expected.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic kind_t random_func();
    return kind_t'($urandom_range(K_SIN, K_LN));
  endfunction

  task automatic add_token(kind_t cmd, logic [REF_WIDTH_DEF-1:0] opref);
    infix_token_t t;
    t.cmd         = cmd;
    t.opref       = opref;
    t.drain_first = hold_next;
    hold_next     = 1'b0;
    infix_tokens.push_back(t);
  endtask

  // Non-operand token; give it a random reference so out_ref zeroing is exercised.
  task automatic add_op(kind_t cmd);
    add_token(cmd, REF_WIDTH_DEF'($urandom_range(0, 65535)));
  endtask

  task automatic gen_operand();
    kind_t k;
    k = K_OPERAND;
    if ($urandom_range(0, 24) == 0) k = $urandom_range(0, 1) ? KIND_SPARE14 : KIND_SPARE15;
    add_token(k, REF_WIDTH_DEF'($urandom_range(0, 65535)));
  endtask

  task automatic gen_factor(int depth);
    int pick;
    pick = (depth >= 3) ? 0 : $urandom_range(0, 6);
    if (pick <= 2) begin
      gen_operand();
    end else if (pick == 3) begin
      add_op(K_LPAREN);
      gen_expr(depth + 1);
      add_op(K_RPAREN);
    end else if (pick == 4) begin
      add_op(random_func());
      add_op(K_LPAREN);
      gen_expr(depth + 1);
      add_op(K_RPAREN);
    end else begin
      add_op(random_func());
      gen_factor(depth + 1);
    end
  endtask

  task automatic gen_term(int depth);
    gen_factor(depth);
    repeat ($urandom_range(0, 2)) begin
      add_op($urandom_range(0, 1) ? K_MUL : K_DIV);
      gen_factor(depth);
    end
  endtask

  task automatic gen_expr(int depth);
    gen_term(depth);
    repeat ($urandom_range(0, 2)) begin
      add_op($urandom_range(0, 1) ? K_PLUS : K_MINUS);
      gen_term(depth);
    end
  endtask

  initial begin
    int r;
    // Directed: field extremes, spare codes, every operator and function,
    // nesting, a close with no open and a leftover open at end.
    add_token(KIND_SPARE14, 16'hFFFF);
    add_op(K_PLUS);
    add_token(K_OPERAND, 16'h0000);
    add_op(K_MUL);
    add_token(KIND_SPARE15, 16'h5555);
    add_op(K_END);
    add_op(K_SIN);
    add_op(KIND_COS);
    add_op(KIND_TAN);
    add_op(KIND_CTG);
    add_op(KIND_SQRT);
    add_op(K_LN);
    add_token(K_OPERAND, 16'hAAAA);
    add_op(K_MINUS);
    add_op(K_LPAREN);
    add_token(K_OPERAND, 16'h0001);
    add_op(K_DIV);
    add_token(K_OPERAND, 16'h8000);
    add_op(K_RPAREN);
    add_op(K_END);
    add_op(K_RPAREN);
    add_op(K_END);
    add_op(K_LPAREN);
    add_token(K_OPERAND, 16'h7FFF);
    add_op(K_END);

    // Full stack: 32 functions then end gives the longest burst of output.
    hold_next = 1'b1;
    repeat (STACK_DEPTH_DEF) add_op(random_func());
    add_op(K_END);
    // Overflow: two more opens than the stack holds.
    repeat (STACK_DEPTH_DEF + 2) add_op(K_LPAREN);
    add_op(K_END);

    // Random: mostly well-formed expressions, some broken, some noise,
    // some deep pushes near the stack limit.
    hold_next = 1'b1;
    while (infix_tokens.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 14) == 0) hold_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 72) begin
        gen_expr(0);
        add_op(K_END);
      end else if (r < 82) begin
        gen_expr(0);
        case ($urandom_range(0, 2))
          0: add_op(K_LPAREN);
          1: add_op(K_RPAREN);
          default: add_op(kind_t'($urandom_range(0, 15)));
        endcase
        if ($urandom_range(0, 1)) gen_expr(0);
        add_op(K_END);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 8)) add_token(kind_t'($urandom_range(0, 15)),
                                                REF_WIDTH_DEF'($urandom_range(0, 65535)));
        if ($urandom_range(0, 1)) add_op(K_END);
      end else begin
        repeat ($urandom_range(STACK_DEPTH_DEF - 4, STACK_DEPTH_DEF + 4))
          add_op($urandom_range(0, 1) ? K_LPAREN : random_func());
        gen_operand();
        repeat ($urandom_range(0, 6)) add_op(K_RPAREN);
        add_op(K_END);
      end
    end

    // Reset, then wait for every transaction to go in and every token to come out.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (infix_tokens.size() != 0 || in_valid) @(posedge clk);
    while (postfix_expected.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_infix_to_postfix_converter_unit OK");
    end else begin
      $display("tb_infix_to_postfix_converter_unit NOT OK");
    end
    $finish;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("tb_infix_to_postfix_converter_unit NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued tokens; hold the payload while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    infix_token_t nxt;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_cmd         <= K_OPERAND;
      in_operand_ref <= '0;
    end else begin
      // Predict at the edge that accepts the transaction.
      if (in_valid && !in_stall) begin
        predict_postfix(in_cmd, in_operand_ref);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (infix_tokens.size() > 0 &&
                     !(infix_tokens[0].drain_first && postfix_expected.size() > 0)) begin
          nxt = infix_tokens.pop_front();
          in_cmd         <= nxt.cmd;
          in_operand_ref <= nxt.opref;
          in_valid       <= 1'b1;
          tx_gap = (tx_quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
          // Toggle between idling and back-to-back stretches now and then.
          if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random short and long holds, plus two long hold-offs
  // while the sender keeps offering, so the sequencer is held and the input stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if ((holds_done == 0 && accepted_items >= 60) ||
                 (holds_done == 1 && accepted_items >= 320)) begin
      holds_done++;
      hold_cycles = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall <= 1'b1;
    end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
      rx_stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted token with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    postfix_token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (postfix_expected.size() == 0) begin
        $display("%0t: token with none expected, expected nothing, actual kind %0d ref %0h",
                 $time, out_kind, out_ref);
        mismatch_count++;
      end else begin
        want = postfix_expected.pop_front();
        check_field("out_kind", 32'(want.kind), 32'(out_kind));
        check_field("out_ref", 32'(want.opref), 32'(out_ref));
        check_field("out_error", 32'(want.err), 32'(out_error));
        check_field("out_last", 32'(want.last), 32'(out_last));
      end
    end
  end

endmodule
